>>> hw/rtl/mfpp_pkg.sv
// Shared types and constants for the marker framed packet parser.
// Holds the sync byte codes, parser phase codes and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfpp_pkg;

  // Sync pair that opens every packet
  localparam logic [7:0] SYNC_FIRST  = 8'h4D;
  localparam logic [7:0] SYNC_SECOND = 8'h50;

  // Header sizes in bytes
  localparam logic [3:0] NUMBER_BYTES = 4'd2;
  localparam logic [3:0] TIME_BYTES   = 4'd8;

  // Parser phase codes
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_HUNT_M  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HUNT_P  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_NUMBER  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TIME    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd5;

  // Depth of the result buffer (main plus spare entry)
  localparam int OUT_DEPTH = 2;

  // One result record
  typedef struct packed {
    logic [15:0] packet_number;
    logic [63:0] timestamp;
    logic [7:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic        has_byte;
    logic        last_of_packet;
    logic        truncated;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/mfpp_parse_core.sv
// Byte-level parser: sync hunt, header collection and payload tagging.
// Updates its state on each accepted byte and presents at most one result.
// Depends on mfpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfpp_parse_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_message,
  output logic                    res_valid,
  output mfpp_pkg::result_t       res
);

  logic [mfpp_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [15:0] number_r, number_nxt;
  logic [63:0] time_r, time_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  pos_r, pos_nxt;

  logic       emit;
  logic       done;
  logic       last;
  logic       has;
  logic       last_flag;
  logic       trunc_flag;
  logic [7:0] out_byte;
  logic [7:0] out_index;

  // Work out next state and the result for the byte at the input
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    number_nxt = number_r;
    time_nxt   = time_r;
    length_nxt = length_r;
    pos_nxt    = pos_r;
    emit       = 1'b0;
    done       = 1'b0;
    has        = 1'b0;
    last_flag  = 1'b0;
    trunc_flag = 1'b0;
    out_byte   = 8'd0;
    out_index  = 8'd0;
    last       = ({1'b0, pos_r} + 9'd1) >= {1'b0, length_r};

    case (phase_r)
      mfpp_pkg::PH_HUNT_M: begin
        if (data_byte == mfpp_pkg::SYNC_FIRST) begin
          phase_nxt = mfpp_pkg::PH_HUNT_P;
        end
      end
      mfpp_pkg::PH_HUNT_P: begin
        if (data_byte == mfpp_pkg::SYNC_SECOND) begin
          phase_nxt  = mfpp_pkg::PH_NUMBER;
          count_nxt  = 4'd0;
          number_nxt = 16'd0;
          time_nxt   = 64'd0;
          length_nxt = 8'd0;
          pos_nxt    = 8'd0;
        end else if (data_byte != mfpp_pkg::SYNC_FIRST) begin
          // a repeated first marker keeps the hunt armed
          phase_nxt = mfpp_pkg::PH_HUNT_M;
        end
      end
      mfpp_pkg::PH_NUMBER: begin
        number_nxt = {number_r[7:0], data_byte};
        count_nxt  = count_r + 4'd1;
        if (count_nxt >= mfpp_pkg::NUMBER_BYTES) begin
          phase_nxt = mfpp_pkg::PH_TIME;
          count_nxt = 4'd0;
        end
      end
      mfpp_pkg::PH_TIME: begin
        time_nxt  = {time_r[55:0], data_byte};
        count_nxt = count_r + 4'd1;
        if (count_nxt >= mfpp_pkg::TIME_BYTES) begin
          phase_nxt = mfpp_pkg::PH_LENGTH;
          count_nxt = 4'd0;
        end
      end
      mfpp_pkg::PH_LENGTH: begin
        length_nxt = data_byte;
        pos_nxt    = 8'd0;
        if (data_byte == 8'd0) begin
          // empty packet: one result without a byte
          emit      = 1'b1;
          done      = 1'b1;
          last_flag = 1'b1;
          phase_nxt = mfpp_pkg::PH_HUNT_M;
        end else begin
          phase_nxt = mfpp_pkg::PH_PAYLOAD;
        end
      end
      mfpp_pkg::PH_PAYLOAD: begin
        emit       = 1'b1;
        done       = 1'b1;
        has        = 1'b1;
        out_byte   = data_byte;
        out_index  = pos_r;
        last_flag  = last | end_of_message;
        trunc_flag = ~last & end_of_message;
        if (last) begin
          phase_nxt = mfpp_pkg::PH_HUNT_M;
        end else begin
          pos_nxt = pos_r + 8'd1;
        end
      end
      default: begin
        phase_nxt = mfpp_pkg::PH_HUNT_M;
      end
    endcase

    // End of message: flag a packet cut short, then hunt again
    if (end_of_message) begin
      if (!done && (phase_nxt inside {mfpp_pkg::PH_NUMBER, mfpp_pkg::PH_TIME,
                                      mfpp_pkg::PH_LENGTH, mfpp_pkg::PH_PAYLOAD})) begin
        emit       = 1'b1;
        has        = 1'b0;
        out_byte   = 8'd0;
        out_index  = 8'd0;
        last_flag  = 1'b1;
        trunc_flag = 1'b1;
      end
      phase_nxt = mfpp_pkg::PH_HUNT_M;
      count_nxt = 4'd0;
    end
  end

  // Present the result built from the updated header
  always_comb begin
    res_valid          = accept & emit;
    res.packet_number  = number_nxt;
    res.timestamp      = time_nxt;
    res.payload_length = length_nxt;
    res.payload_byte   = out_byte;
    res.byte_index     = out_index;
    res.has_byte       = has;
    res.last_of_packet = last_flag;
    res.truncated      = trunc_flag;
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mfpp_pkg::PH_HUNT_M;
      count_r  <= 4'd0;
      number_r <= 16'd0;
      time_r   <= 64'd0;
      length_r <= 8'd0;
      pos_r    <= 8'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      number_r <= number_nxt;
      time_r   <= time_nxt;
      length_r <= length_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mfpp_out_buf.sv
// Result register with a spare entry, so the parser keeps taking bytes
// while a finished result waits downstream. Depends on mfpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfpp_out_buf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire mfpp_pkg::result_t  push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output mfpp_pkg::result_t       pop_data
);

  mfpp_pkg::result_t main_r;
  mfpp_pkg::result_t spare_r;
  logic main_valid_r;
  logic spare_valid_r;
  logic push;
  logic pop;

  assign push_ready = ~spare_valid_r;
  assign pop_valid  = main_valid_r;
  assign pop_data   = main_r;
  assign push       = push_valid & push_ready;
  assign pop        = main_valid_r & pop_ready;

  // Track occupancy of main and spare entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r  <= 1'b0;
      spare_valid_r <= 1'b0;
    end else if (spare_valid_r) begin
      if (pop) begin
        spare_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        spare_valid_r <= 1'b1;
      end
      main_valid_r <= 1'b1;
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  // Move result records between entries
  always_ff @(posedge clk) begin
    if (spare_valid_r) begin
      if (pop) begin
        main_r <= spare_r;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_r <= push_data;
      end else begin
        spare_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/marker_framed_packet_parser_unit.sv
// Marker framed packet parser: takes one byte per cycle while in_ready is
// high, hunts for the sync pair 'M','P', collects a 16-bit packet number, a
// 64-bit timestamp and a length byte, then tags each payload byte with the
// header. A new byte is accepted every cycle as long as the two-entry result
// buffer has room, and each result is registered in the buffer before it
// appears on the out_ port. The parser state register is updated once per
// accepted byte.
// Depends on mfpp_pkg, mfpp_parse_core and mfpp_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module marker_framed_packet_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_packet_number,
  output logic [63:0]      out_timestamp,
  output logic [7:0]       out_payload_length,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_byte_index,
  output logic             out_has_byte,
  output logic             out_last_of_packet,
  output logic             out_truncated
);

  logic              accept;
  logic              res_valid;
  mfpp_pkg::result_t res;
  mfpp_pkg::result_t out_rec;

  assign accept = in_valid & in_ready;

  // Parse the accepted byte
  mfpp_parse_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_data_byte),
    .end_of_message (in_end_of_message),
    .res_valid      (res_valid),
    .res            (res)
  );

  // Hold results until taken
  mfpp_out_buf u_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_ready (in_ready),
    .push_data  (res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_rec)
  );

  assign out_packet_number  = out_rec.packet_number;
  assign out_timestamp      = out_rec.timestamp;
  assign out_payload_length = out_rec.payload_length;
  assign out_payload_byte   = out_rec.payload_byte;
  assign out_byte_index     = out_rec.byte_index;
  assign out_has_byte       = out_rec.has_byte;
  assign out_last_of_packet = out_rec.last_of_packet;
  assign out_truncated      = out_rec.truncated;

endmodule

`default_nettype wire

>>> hw/rtl/mfpp_checker.sv
// Port-level checks for the marker framed packet parser, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module mfpp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_packet_number,
  input wire logic [63:0] out_timestamp,
  input wire logic [7:0]  out_payload_length,
  input wire logic [7:0]  out_payload_byte,
  input wire logic [7:0]  out_byte_index,
  input wire logic        out_has_byte,
  input wire logic        out_last_of_packet,
  input wire logic        out_truncated
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_packet_number) &&
      $stable(out_timestamp) && $stable(out_payload_byte) && $stable(out_byte_index) &&
      $stable(out_has_byte) && $stable(out_last_of_packet) && $stable(out_truncated))
    else $error("result changed while stalled");

  // A truncated or byteless result always closes its packet
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_truncated || !out_has_byte) |-> out_last_of_packet)
    else $error("closing result without last_of_packet");

  // A byteless result carries zero byte and index
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_payload_byte == 8'd0 && out_byte_index == 8'd0)
    else $error("byteless result with nonzero byte fields");

  // Payload index stays inside the length; only the final byte is last
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_byte && !out_truncated |->
      out_byte_index < out_payload_length &&
      (out_last_of_packet == ({1'b0, out_byte_index} + 9'd1 == {1'b0, out_payload_length})))
    else $error("payload index inconsistent with length");

endmodule

bind marker_framed_packet_parser_unit mfpp_checker u_mfpp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_packet_number  (out_packet_number),
  .out_timestamp      (out_timestamp),
  .out_payload_length (out_payload_length),
  .out_payload_byte   (out_payload_byte),
  .out_byte_index     (out_byte_index),
  .out_has_byte       (out_has_byte),
  .out_last_of_packet (out_last_of_packet),
  .out_truncated      (out_truncated)
);

`default_nettype wire
